### src/assert_macros.svh
// Assertion macros shared by the unique value stack modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define UVS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define UVS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define UVS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### src/uvs_pkg.sv
// Types, constants and codes shared by the unique value stack.
package uvs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 4;
	localparam int ECNT_W    = 5;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_FIND = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_FULL  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SCAN_END,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_issue;
		logic read_issue;
		logic cmp;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic last_issue;
		logic match;
		logic pos_ok;
		logic out_free;
	} sts_t;

endpackage

### src/uvs_if.sv
// Request and response channel interfaces of the unique value stack.
interface uvs_req_if;
	import uvs_pkg::*;

	logic                     valid;
	logic                     ready;
	op_t                      func;
	logic signed [VAL_W-1:0]  item_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output func, output item_value, output position,
		input ready);
	modport sink (input valid, input func, input item_value, input position,
		output ready);
endinterface

interface uvs_rsp_if;
	import uvs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  result_value;
	logic [POS_W-1:0]         found_position;
	logic                     found;
	logic [ECNT_W-1:0]        entry_count;
	status_t                  status;

	modport source (output valid, output result_value, output found_position,
		output found, output entry_count, output status, input ready);
	modport sink (input valid, input result_value, input found_position,
		input found, input entry_count, input status, output ready);
endinterface

### src/uvs_ctrl.sv
// Controller state machine of the unique value stack.
`include "assert_macros.svh"

module uvs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  uvs_pkg::sts_t sts,
	output uvs_pkg::cmd_t cmd
);
	import uvs_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_PUSH, OP_FIND: begin
						state_d = sts.cnt_zero ? S_FINISH : S_SCAN;
					end
					OP_POP: begin
						cmd.read_issue = !sts.cnt_zero;
						state_d        = S_FINISH;
					end
					OP_READ: begin
						cmd.read_issue = sts.pos_ok;
						state_d        = S_FINISH;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SCAN: begin
				// Issue one entry read per cycle; compare the one read before.
				cmd.cmp        = 1'b1;
				cmd.scan_issue = !sts.match;
				if (sts.match) begin
					state_d = S_FINISH;
				end else if (sts.last_issue) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				cmd.cmp = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`UVS_ASSERT(a_scan_nonempty, clk, arst_n, (state_q == S_SCAN) |-> !sts.cnt_zero, "scan of an empty stack")
	`UVS_ASSERT(a_scan_op, clk, arst_n, (state_q == S_SCAN) |-> (sts.op == OP_PUSH || sts.op == OP_FIND), "scan for an operation that needs none")
endmodule

### src/uvs_datapath.sv
// Datapath of the unique value stack: entry memory, scan compare and result register.
`include "assert_macros.svh"

module uvs_datapath #(
	parameter int DEPTH = uvs_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  uvs_pkg::cmd_t                    cmd,
	output uvs_pkg::sts_t                    sts,
	input  uvs_pkg::op_t                     func,
	input  logic signed [uvs_pkg::VAL_W-1:0] item_value,
	input  logic [uvs_pkg::POS_W-1:0]        position,
	input  logic                             rsp_ready,
	output logic                             rsp_valid,
	output logic signed [uvs_pkg::VAL_W-1:0] result_value,
	output logic [uvs_pkg::POS_W-1:0]        found_position,
	output logic                             found,
	output logic [uvs_pkg::ECNT_W-1:0]       entry_count,
	output uvs_pkg::status_t                 status
);
	import uvs_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [VAL_W-1:0] mem [DEPTH];

	op_t                     op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        addr_q;
	logic                    hit_q;
	logic [AW-1:0]           hit_idx_q;
	logic                    chk_v_s1;
	logic [AW-1:0]           chk_idx_s1;
	logic signed [VAL_W-1:0] rd_s1;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] res_q;
	logic [POS_W-1:0]        fpos_q;
	logic                    found_q;
	logic [ECNT_W-1:0]       ecnt_q;
	status_t                 status_q;

	logic [CNT_W-1:0]        cnt_m1;
	logic                    cnt_zero;
	logic                    full;
	logic                    pos_ok;
	logic                    match;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [31:0]             cnt_nxt_ext;

	logic signed [VAL_W-1:0] res_d;
	logic [POS_W-1:0]        fpos_d;
	logic                    found_d;
	status_t                 st_d;
	logic [CNT_W-1:0]        cnt_nxt;

	// Count and position checks.
	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_zero = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign pos_ok   = (32'(pos_q) < 32'(count_q));
	assign match    = chk_v_s1 && (rd_s1 == val_q);

	// Status toward the controller.
	always_comb begin
		sts.op         = op_q;
		sts.cnt_zero   = cnt_zero;
		sts.last_issue = (addr_q == cnt_m1);
		sts.match      = match;
		sts.pos_ok     = pos_ok;
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	// Read address: scan counter, top entry for a pop, or the requested position.
	always_comb begin
		rd_en = cmd.scan_issue || cmd.read_issue;
		if (cmd.scan_issue) begin
			rd_addr = addr_q[AW-1:0];
		end else if (op_q == OP_POP) begin
			rd_addr = cnt_m1[AW-1:0];
		end else begin
			rd_addr = AW'(pos_q);
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= val_q;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// Request word capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= item_value;
			pos_q <= position;
		end
		if (cmd.scan_issue) begin
			chk_idx_s1 <= addr_q[AW-1:0];
		end
		if (cmd.cmp && match) begin
			hit_idx_q <= chk_idx_s1;
		end
	end

	// Result of the finished operation.
	always_comb begin
		res_d   = '0;
		fpos_d  = '0;
		found_d = 1'b0;
		st_d    = ST_OK;
		cnt_nxt = count_q;
		wr_en   = 1'b0;
		unique case (op_q)
			OP_PUSH: begin
				if (hit_q) begin
					found_d = 1'b1;
					fpos_d  = POS_W'(hit_idx_q);
					st_d    = ST_DUP;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					wr_en   = cmd.finish;
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (cnt_zero) begin
					st_d = ST_EMPTY;
				end else begin
					res_d   = rd_s1;
					cnt_nxt = cnt_m1;
				end
			end
			OP_FIND: begin
				found_d = hit_q;
				fpos_d  = hit_q ? POS_W'(hit_idx_q) : '0;
			end
			OP_READ: begin
				if (pos_ok) begin
					res_d = rd_s1;
				end else begin
					st_d = ST_RANGE;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign cnt_nxt_ext = 32'(cnt_nxt);

	// Control registers: operation, count, scan pointer, hit flag, compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_PUSH;
			count_q  <= '0;
			addr_q   <= '0;
			hit_q    <= 1'b0;
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= cmd.scan_issue;
			if (cmd.load) begin
				op_q   <= func;
				addr_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					addr_q <= addr_q + CNT_W'(1);
				end
				if (cmd.cmp && match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q <= cnt_nxt;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q    <= res_d;
			fpos_q   <= fpos_d;
			found_q  <= found_d;
			ecnt_q   <= cnt_nxt_ext[ECNT_W-1:0];
			status_q <= st_d;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign result_value   = res_q;
	assign found_position = fpos_q;
	assign found          = found_q;
	assign entry_count    = ecnt_q;
	assign status         = status_q;

	`UVS_ASSERT_NEVER(a_cnt_max, clk, arst_n, count_q > CNT_W'(DEPTH), "entry count above depth")
	`UVS_ASSERT(a_cnt_hold, clk, arst_n, !cmd.finish |=> $stable(count_q), "count moved outside finish")
	`UVS_ASSERT(a_out_set, clk, arst_n, cmd.finish |=> out_valid_q, "finished word not presented")
	`UVS_ASSERT(a_dup_found, clk, arst_n, (out_valid_q && status_q == ST_DUP) |-> found_q, "duplicate without found flag")
endmodule

### src/unique_value_stack_top.sv
// Top level of the unique value stack: controller, datapath and channel wiring.
// Push and find scan the stored entries one per cycle through the single memory
// read port, and an empty stack skips the scan; pop and read need at most one read.
// A new request word is taken only once the last result is registered, and a
// response that is not taken holds the stack in its finish state.
// Asynchronous reset empties the stack; entry memory is not cleared.
module unique_value_stack_top #(
	parameter int DEPTH = uvs_pkg::DEPTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	uvs_req_if.sink   req,
	uvs_rsp_if.source rsp
);
	import uvs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	// Sequencing of each word.
	uvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage, compare and response register.
	uvs_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (req.func),
		.item_value     (req.item_value),
		.position       (req.position),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.result_value   (rsp.result_value),
		.found_position (rsp.found_position),
		.found          (rsp.found),
		.entry_count    (rsp.entry_count),
		.status         (rsp.status)
	);
endmodule

### sim/tb.sv
// Testbench for the unique value stack: directed and random words checked against a stack predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import uvs_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int RANDOM_WORDS = 200;
	localparam int POOL_SIZE = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

	// One response word as the stack should produce it.
	typedef struct {
		logic signed [VAL_W-1:0] result_value;
		logic [POS_W-1:0]        found_position;
		logic                    found;
		logic [ECNT_W-1:0]       entry_count;
		status_t                 status;
	} stack_reply_t;

	// Tracks the stack contents and queues the reply each accepted request must cause.
	class unique_stack_model;
		logic signed [VAL_W-1:0] entries [DEPTH];
		int count;
		int errors;
		stack_reply_t pending_replies[$];

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void note_word(op_t f, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
			stack_reply_t r;
			int hit;
			r.result_value = '0;
			r.found_position = '0;
			r.found = 1'b0;
			r.status = ST_OK;
			// Lowest stored position that holds the value, or -1.
			hit = -1;
			for (int i = count - 1; i >= 0; i--) begin
				if (entries[i] == v)
					hit = i;
			end
			case (f)
				OP_PUSH: begin
					// A duplicate is reported even when the stack is full.
					if (hit >= 0) begin
						r.found = 1'b1;
						r.found_position = hit[POS_W-1:0];
						r.status = ST_DUP;
					end else if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						entries[count] = v;
						count++;
					end
				end
				OP_POP: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						count--;
						r.result_value = entries[count];
					end
				end
				OP_FIND: begin
					if (hit >= 0) begin
						r.found = 1'b1;
						r.found_position = hit[POS_W-1:0];
					end
				end
				default: begin
					if (p < count)
						r.result_value = entries[p];
					else
						r.status = ST_RANGE;
				end
			endcase
			r.entry_count = count[ECNT_W-1:0];
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, actual %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_reply(stack_reply_t act);
			stack_reply_t e;
			if (pending_replies.size() == 0) begin
				$error("reply word with no request waiting: result_value %0h status %0d",
					act.result_value, act.status);
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			compare_field("result_value", e.result_value, act.result_value);
			compare_field("found_position", 32'(e.found_position), 32'(act.found_position));
			compare_field("found", 32'(e.found), 32'(act.found));
			compare_field("entry_count", 32'(e.entry_count), 32'(act.entry_count));
			compare_field("status", 32'(e.status), 32'(act.status));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic signed [VAL_W-1:0] value_pool [POOL_SIZE];
	unique_stack_model sb;
	stack_reply_t seen;

	uvs_req_if req_ch ();
	uvs_rsp_if rsp_ch ();

	unique_value_stack_top #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Response side stalls at random; ready changes on the falling edge.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Every response word taken is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.result_value = rsp_ch.result_value;
			seen.found_position = rsp_ch.found_position;
			seen.found = rsp_ch.found;
			seen.entry_count = rsp_ch.entry_count;
			seen.status = rsp_ch.status;
			sb.check_reply(seen);
		end
	end

	// Offers one request word, with random gaps before it, and waits until it is taken.
	// Called and returning just after a falling edge, with valid left high.
	task automatic send_word(input op_t f, input logic signed [VAL_W-1:0] v,
		input logic [POS_W-1:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.item_value <= $urandom;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.item_value <= v;
		req_ch.position <= p;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_word(f, v, p);
		@(negedge clk);
	endtask

	// Random request word; grow favors pushes so the stack fills, otherwise pops dominate.
	task automatic send_random_word(input bit grow);
		op_t f;
		logic signed [VAL_W-1:0] v;
		logic [POS_W-1:0] p;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			f = OP_FIND;
		else if (pick < 30)
			f = OP_READ;
		else if ((pick < 85) == grow)
			f = OP_PUSH;
		else
			f = OP_POP;
		// A small pool of values makes duplicates and find hits common.
		if ($urandom_range(99) < 60)
			v = value_pool[$urandom_range(POOL_SIZE-1)];
		else
			v = $urandom;
		if (sb.count > 0 && $urandom_range(1) == 1)
			p = POS_W'($urandom_range(sb.count - 1));
		else
			p = POS_W'($urandom_range(DEPTH - 1));
		send_word(f, v, p);
	endtask

	initial begin
		int run_len;
		bit grow;
		req_ch.valid = 1'b0;
		req_ch.func = OP_PUSH;
		req_ch.item_value = '0;
		req_ch.position = '0;
		sb = new();
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = '1;
		value_pool[4] = 1;
		for (int i = 5; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty stack: pop, read and find all come back empty-handed.
		send_word(OP_POP, '0, '0);
		send_word(OP_READ, '0, '0);
		send_word(OP_FIND, '0, '0);
		// Extreme values, a duplicate push and a read at the count.
		send_word(OP_PUSH, VAL_MIN, '0);
		send_word(OP_PUSH, VAL_MAX, 4'hf);
		send_word(OP_PUSH, VAL_MIN, '0);
		send_word(OP_FIND, VAL_MAX, '0);
		send_word(OP_READ, '0, 4'd1);
		send_word(OP_READ, '0, 4'd2);
		// Fill to the top, including zero and minus one.
		for (int i = 2; i < DEPTH; i++)
			send_word(OP_PUSH, (i == 2) ? '0 : (i == 3) ? '1 : VAL_W'(i) * 32'h0102_0304,
				'0);
		// Full stack: a new value is refused, a duplicate is still reported as such.
		send_word(OP_PUSH, 32'sh0bad_f00d, '0);
		send_word(OP_PUSH, VAL_MAX, '0);
		send_word(OP_FIND, 32'sh0f1e_2d3c, '0);
		send_word(OP_READ, '0, 4'hf);
		send_word(OP_POP, '0, '0);

		// Random words under each idling pattern, alternating fill and drain runs.
		grow = 1'b1;
		run_len = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 50;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 50;
				end
				default: begin
					src_idle_pct = 25;
					sink_stall_pct = 25;
				end
			endcase
			for (int k = 0; k < RANDOM_WORDS; k++) begin
				if (run_len == 0) begin
					grow = !grow;
					run_len = $urandom_range(20, 60);
				end
				run_len--;
				send_random_word(grow);
			end
		end
		req_ch.valid <= 1'b0;

		// Drain the outstanding replies, then watch for stray words.
		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
